### hw/rtl/gpq_pkg.sv
// ----------------------------------------------------------------------------
// gpq_pkg
// Shared types, codes and helper functions of the greedy palette quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpq_pkg;

   // Mask of the color bits that form a group key (top nibble of each channel).
   localparam logic [31:0] KEY_NIBBLES = 32'hf0f0f0f0;

   // Command codes of an input word.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Result kinds.
   localparam logic KIND_PALETTE = 1'b0;
   localparam logic KIND_INDEX   = 1'b1;

   // Error codes of a result word.
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

   // A classified input word as it travels from the front end to the engine.
   typedef struct packed {
      logic        query;
      logic        last;
      logic [31:0] argb;
      logic [15:0] key;
   } item_type;

   // One result word.
   typedef struct packed {
      logic        kind;
      logic [31:0] palette_argb;
      logic [3:0]  color_index;
      logic [1:0]  error;
      logic        last;
   } rsp_type;

   // Group key: top nibbles of A, R, G and B packed into 16 bits.
   function automatic logic [15:0] color_key(input logic [31:0] argb);
      logic [31:0] m;
      m = argb & KEY_NIBBLES;
      return {m[31:28], m[23:20], m[15:12], m[7:4]};
   endfunction

   // Squared distance of one 8-bit channel.
   function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

   // Squared RGB distance of two colors; alpha does not take part.
   function automatic logic [17:0] rgb_dist(input logic [31:0] x, input logic [31:0] y);
      return 18'(chan_sq(x[23:16], y[23:16])) + 18'(chan_sq(x[15:8], y[15:8]))
           + 18'(chan_sq(x[7:0], y[7:0]));
   endfunction

endpackage

### hw/rtl/gpq_if.sv
// ----------------------------------------------------------------------------
// gpq_if
// Valid/ready channels of the quantizer: request words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] pixel_argb;
   logic        last_pixel;

   modport source (output valid, cmd, pixel_argb, last_pixel, input ready);
   modport sink   (input valid, cmd, pixel_argb, last_pixel, output ready);
endinterface

interface gpq_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] palette_argb;
   logic [3:0]  color_index;
   logic [1:0]  error;
   logic        last;

   modport source (output valid, kind, palette_argb, color_index, error, last, input ready);
   modport sink   (input valid, kind, palette_argb, color_index, error, last, output ready);
endinterface

### hw/rtl/gpq_front.sv
// ----------------------------------------------------------------------------
// gpq_front
// Accepts request words, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpq_front (
   input  logic              clock,
   input  logic              reset,
   gpq_req_if.sink           req,
   output logic              q_valid,
   output gpq_pkg::item_type q_item,
   input  logic              q_pop
);

   gpq_pkg::item_type fifo_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   gpq_pkg::item_type new_item;

   // Classify the incoming word.
   always_comb begin
      new_item.query = (req.cmd == gpq_pkg::CMD_QUERY);
      new_item.last  = req.last_pixel;
      new_item.argb  = req.pixel_argb;
      new_item.key   = gpq_pkg::color_key(req.pixel_argb);
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = fifo_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping of the two-entry queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### hw/rtl/gpq_div.sv
// ----------------------------------------------------------------------------
// gpq_div
// Restoring divider that yields an 8-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpq_div #(
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW+7:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [7:0]    quo
);

   localparam int TW = DW + 8;

   logic [TW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [7:0]    quo_ff, quo_in;
   logic [2:0]    step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [TW-1:0] trial;
   logic          fits;

   assign trial = TW'(den_ff) << step_ff;
   assign fits  = (rem_ff >= trial);
   assign done  = done_ff;
   assign quo   = quo_ff;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quo_in  = 8'd0;
         step_in = 3'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial;
         end
         quo_in[step_ff] = fits;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

endmodule

### hw/rtl/gpq_back.sv
// ----------------------------------------------------------------------------
// gpq_back
// Execution engine: key map and group tables, merge loop, ranking, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpq_back #(
   parameter int MAX_PIXELS   = 4096,
   parameter int PALETTE_SIZE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  gpq_pkg::item_type q_item,
   output logic              q_pop,
   gpq_rsp_if.source         rsp
);

   localparam int GW   = $clog2(MAX_PIXELS);
   localparam int CW   = $clog2(MAX_PIXELS + 1);
   localparam int PW   = $clog2(PALETTE_SIZE);
   localparam int EMIT = (PALETTE_SIZE < 16) ? PALETTE_SIZE : 16;

   typedef enum logic [22:0] {
      ST_IDLE  = 23'd1 << 0,
      ST_KEY   = 23'd1 << 1,
      ST_KGRP  = 23'd1 << 2,
      ST_DEC   = 23'd1 << 3,
      ST_QWAIT = 23'd1 << 4,
      ST_QCHK  = 23'd1 << 5,
      ST_PWAIT = 23'd1 << 6,
      ST_QOUT  = 23'd1 << 7,
      ST_MCHK  = 23'd1 << 8,
      ST_MIN   = 23'd1 << 9,
      ST_NEAR  = 23'd1 << 10,
      ST_BMUL1 = 23'd1 << 11,
      ST_BMUL2 = 23'd1 << 12,
      ST_BDIV  = 23'd1 << 13,
      ST_BWR   = 23'd1 << 14,
      ST_RSEL  = 23'd1 << 15,
      ST_RWAIT = 23'd1 << 16,
      ST_RCHK  = 23'd1 << 17,
      ST_RSCAN = 23'd1 << 18,
      ST_RWR   = 23'd1 << 19,
      ST_EADDR = 23'd1 << 20,
      ST_EWAIT = 23'd1 << 21,
      ST_EOUT  = 23'd1 << 22
   } state_type;

   // Memories.
   logic [GW-1:0] key_map   [65536];
   logic [15:0]   grp_key   [2**GW];
   logic [31:0]   grp_color [2**GW];
   logic [CW-1:0] grp_count [2**GW];
   logic [GW-1:0] grp_merge [2**GW];
   logic [PW-1:0] grp_slot  [2**GW];
   logic [31:0]   pal_color [2**PW];

   // Registered read data.
   logic [GW-1:0] km_q;
   logic [15:0]   gk_q;
   logic [31:0]   col_q;
   logic [CW-1:0] cnt_q;
   logic [GW-1:0] mrg_q;
   logic [PW-1:0] slot_q;
   logic [31:0]   pal_q;

   // Control state.
   state_type     state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] loaded_ff, loaded_in;
   logic          ovf_ff, ovf_in;
   logic          done_ff, done_in;
   logic [CW-1:0] live_ff, live_in;
   logic          iss_ff, iss_in;
   logic          pv_ff, pv_in;
   logic          out_valid_ff, out_valid_in;

   // Working registers.
   gpq_pkg::item_type item_ff, item_in;
   gpq_pkg::rsp_type  out_ff, out_in;
   logic [GW-1:0] gaddr_ff, gaddr_in;
   logic [GW-1:0] pidx_ff, pidx_in;
   logic          have_ff, have_in;
   logic [GW-1:0] v_ff, v_in;
   logic [CW-1:0] vcnt_ff, vcnt_in;
   logic [31:0]   vcol_ff, vcol_in;
   logic [GW-1:0] s_ff, s_in;
   logic [CW-1:0] scnt_ff, scnt_in;
   logic [31:0]   scol_ff, scol_in;
   logic [17:0]   bd_ff, bd_in;
   logic [1:0]    ch_ff, ch_in;
   logic [31:0]   res_ff, res_in;
   logic [CW+7:0] p1_ff, p1_in;
   logic [CW-1:0] g_ff, g_in;
   logic [CW-1:0] gcnt_ff, gcnt_in;
   logic [31:0]   gcol_ff, gcol_in;
   logic [PW-1:0] rank_ff, rank_in;
   logic [PW-1:0] paddr_ff, paddr_in;
   logic [PW-1:0] qslot_ff, qslot_in;
   logic          qerr_ff, qerr_in;
   logic [3:0]    ei_ff, ei_in;

   // Combinational helpers.
   logic [GW-1:0] grp_raddr;
   logic          hit;
   logic          alive;
   logic          can_emit;
   logic          scan_done;
   logic [CW-1:0] tot;
   logic [17:0]   cand_dist;
   logic [CW+7:0] num;
   logic          div_start;
   logic          div_done;
   logic [7:0]    div_quo;
   logic [GW-1:0] new_grp;

   // Write ports.
   logic          km_we, gk_we, col_we, cnt_we, mrg_we, slot_we, pal_we;
   logic [GW-1:0] col_wa, cnt_wa, mrg_wa;
   logic [31:0]   col_wd;
   logic [CW-1:0] cnt_wd;
   logic [GW-1:0] mrg_wd;

   assign grp_raddr = (state_ff == ST_KGRP) ? km_q : gaddr_ff;
   assign hit       = (CW'(km_q) < total_ff) && (gk_q == item_ff.key);
   assign alive     = (mrg_q == pidx_ff);
   assign can_emit  = !out_valid_ff || rsp.ready;
   assign scan_done = !iss_ff && !pv_ff;
   assign tot       = CW'(scnt_ff + vcnt_ff);
   assign cand_dist = gpq_pkg::rgb_dist(col_q, vcol_ff);
   assign num       = p1_ff + (CW+8)'(vcol_ff[8*ch_ff +: 8]) * (CW+8)'(vcnt_ff);
   assign div_start = (state_ff == ST_BMUL2);
   assign new_grp   = total_ff[GW-1:0];
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   gpq_div #(.DW(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (tot),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Memory write selection.
   always_comb begin
      km_we   = 1'b0;
      gk_we   = 1'b0;
      col_we  = 1'b0;
      cnt_we  = 1'b0;
      mrg_we  = 1'b0;
      slot_we = 1'b0;
      pal_we  = 1'b0;
      col_wa  = new_grp;
      col_wd  = item_ff.argb;
      cnt_wa  = new_grp;
      cnt_wd  = CW'(1);
      mrg_wa  = new_grp;
      mrg_wd  = new_grp;
      if (state_ff == ST_DEC && !item_ff.query && loaded_ff < CW'(MAX_PIXELS)) begin
         if (hit) begin
            cnt_we = 1'b1;
            cnt_wa = km_q;
            cnt_wd = cnt_q + CW'(1);
         end else begin
            km_we  = 1'b1;
            gk_we  = 1'b1;
            col_we = 1'b1;
            cnt_we = 1'b1;
            mrg_we = 1'b1;
         end
      end
      if (state_ff == ST_BWR) begin
         col_we = 1'b1;
         col_wa = s_ff;
         col_wd = res_ff;
         cnt_we = 1'b1;
         cnt_wa = s_ff;
         cnt_wd = tot;
         mrg_we = 1'b1;
         mrg_wa = v_ff;
         mrg_wd = s_ff;
      end
      if (state_ff == ST_RWR) begin
         slot_we = 1'b1;
         pal_we  = 1'b1;
      end
   end

   // Memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (km_we) begin
         key_map[item_ff.key] <= new_grp;
      end
      km_q <= key_map[item_ff.key];
   end

   always_ff @(posedge clock) begin
      if (gk_we) begin
         grp_key[new_grp] <= item_ff.key;
      end
      gk_q <= grp_key[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         grp_color[col_wa] <= col_wd;
      end
      col_q <= grp_color[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         grp_count[cnt_wa] <= cnt_wd;
      end
      cnt_q <= grp_count[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (mrg_we) begin
         grp_merge[mrg_wa] <= mrg_wd;
      end
      mrg_q <= grp_merge[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         grp_slot[g_ff[GW-1:0]] <= rank_ff;
      end
      slot_q <= grp_slot[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_color[rank_ff] <= gcol_ff;
      end
      pal_q <= pal_color[paddr_ff];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      loaded_in    = loaded_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      live_in      = live_ff;
      iss_in       = iss_ff;
      pv_in        = pv_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      item_in      = item_ff;
      out_in       = out_ff;
      gaddr_in     = gaddr_ff;
      pidx_in      = pidx_ff;
      have_in      = have_ff;
      v_in         = v_ff;
      vcnt_in      = vcnt_ff;
      vcol_in      = vcol_ff;
      s_in         = s_ff;
      scnt_in      = scnt_ff;
      scol_in      = scol_ff;
      bd_in        = bd_ff;
      ch_in        = ch_ff;
      res_in       = res_ff;
      p1_in        = p1_ff;
      g_in         = g_ff;
      gcnt_in      = gcnt_ff;
      gcol_in      = gcol_ff;
      rank_in      = rank_ff;
      paddr_in     = paddr_ff;
      qslot_in     = qslot_ff;
      qerr_in      = qerr_ff;
      ei_in        = ei_ff;

      // Pipelined walk over the group table, one entry per cycle.
      if (state_ff == ST_MIN || state_ff == ST_NEAR || state_ff == ST_RSCAN) begin
         gaddr_in = gaddr_ff + GW'(1);
         iss_in   = iss_ff && ((CW'(gaddr_ff) + CW'(1)) < total_ff);
         pv_in    = iss_ff;
         pidx_in  = gaddr_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               state_in = ST_KEY;
               // A load after a finished image starts a new image.
               if (!q_item.query && done_ff) begin
                  total_in  = '0;
                  loaded_in = '0;
                  ovf_in    = 1'b0;
                  done_in   = 1'b0;
               end
            end
         end
         ST_KEY: begin
            state_in = ST_KGRP;
         end
         ST_KGRP: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (item_ff.query) begin
               if (!done_ff || !hit) begin
                  qerr_in  = 1'b1;
                  state_in = ST_QOUT;
               end else begin
                  qerr_in  = 1'b0;
                  gaddr_in = km_q;
                  state_in = ST_QWAIT;
               end
            end else begin
               if (loaded_ff >= CW'(MAX_PIXELS)) begin
                  ovf_in = 1'b1;
               end else begin
                  if (!hit) begin
                     total_in = total_ff + CW'(1);
                  end
                  loaded_in = loaded_ff + CW'(1);
               end
               live_in  = total_in;
               state_in = item_ff.last ? ST_MCHK : ST_IDLE;
            end
         end
         // Follow the merge chain to the surviving group.
         ST_QWAIT: begin
            state_in = ST_QCHK;
         end
         ST_QCHK: begin
            if (mrg_q == gaddr_ff) begin
               paddr_in = slot_q;
               qslot_in = slot_q;
               state_in = ST_PWAIT;
            end else begin
               gaddr_in = mrg_q;
               state_in = ST_QWAIT;
            end
         end
         ST_PWAIT: begin
            state_in = ST_QOUT;
         end
         ST_QOUT: begin
            if (can_emit) begin
               out_valid_in        = 1'b1;
               out_in.kind         = gpq_pkg::KIND_INDEX;
               out_in.palette_argb = qerr_ff ? 32'd0 : pal_q;
               out_in.color_index  = qerr_ff ? 4'd0 : 4'(qslot_ff);
               out_in.error        = qerr_ff ? gpq_pkg::ERR_UNKNOWN : gpq_pkg::ERR_OK;
               out_in.last         = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         // Merge loop: runs while more groups live than palette slots.
         ST_MCHK: begin
            if (32'(live_ff) > 32'(PALETTE_SIZE)) begin
               have_in  = 1'b0;
               gaddr_in = '0;
               iss_in   = 1'b1;
               pv_in    = 1'b0;
               state_in = ST_MIN;
            end else begin
               g_in     = '0;
               state_in = ST_RSEL;
            end
         end
         ST_MIN: begin
            if (pv_ff && alive && (!have_ff || cnt_q <= vcnt_ff)) begin
               v_in    = pidx_ff;
               vcnt_in = cnt_q;
               vcol_in = col_q;
               have_in = 1'b1;
            end
            if (scan_done) begin
               have_in  = 1'b0;
               gaddr_in = '0;
               iss_in   = 1'b1;
               pv_in    = 1'b0;
               state_in = ST_NEAR;
            end
         end
         ST_NEAR: begin
            if (pv_ff && alive && pidx_ff != v_ff &&
                (!have_ff || cand_dist < bd_ff ||
                 (cand_dist == bd_ff && cnt_q > scnt_ff))) begin
               s_in    = pidx_ff;
               scnt_in = cnt_q;
               scol_in = col_q;
               bd_in   = cand_dist;
               have_in = 1'b1;
            end
            if (scan_done) begin
               ch_in    = 2'd0;
               state_in = ST_BMUL1;
            end
         end
         // Weighted average, one channel at a time.
         ST_BMUL1: begin
            p1_in    = (CW+8)'(scol_ff[8*ch_ff +: 8]) * (CW+8)'(scnt_ff);
            state_in = ST_BMUL2;
         end
         ST_BMUL2: begin
            state_in = ST_BDIV;
         end
         ST_BDIV: begin
            if (div_done) begin
               res_in[8*ch_ff +: 8] = div_quo;
               if (ch_ff == 2'd3) begin
                  state_in = ST_BWR;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_BMUL1;
               end
            end
         end
         ST_BWR: begin
            live_in  = live_ff - CW'(1);
            state_in = ST_MCHK;
         end
         // Ranking: each survivor counts the survivors ahead of it.
         ST_RSEL: begin
            if (g_ff < total_ff) begin
               gaddr_in = g_ff[GW-1:0];
               state_in = ST_RWAIT;
            end else begin
               ei_in    = 4'd0;
               state_in = ST_EADDR;
            end
         end
         ST_RWAIT: begin
            state_in = ST_RCHK;
         end
         ST_RCHK: begin
            if (mrg_q == gaddr_ff) begin
               gcnt_in  = cnt_q;
               gcol_in  = col_q;
               rank_in  = '0;
               gaddr_in = '0;
               iss_in   = 1'b1;
               pv_in    = 1'b0;
               state_in = ST_RSCAN;
            end else begin
               g_in     = g_ff + CW'(1);
               state_in = ST_RSEL;
            end
         end
         ST_RSCAN: begin
            if (pv_ff && alive && (cnt_q > gcnt_ff ||
                (cnt_q == gcnt_ff && CW'(pidx_ff) < g_ff))) begin
               rank_in = rank_ff + PW'(1);
            end
            if (scan_done) begin
               state_in = ST_RWR;
            end
         end
         ST_RWR: begin
            g_in     = g_ff + CW'(1);
            state_in = ST_RSEL;
         end
         // Palette words in slot order.
         ST_EADDR: begin
            paddr_in = PW'(ei_ff);
            state_in = ST_EWAIT;
         end
         ST_EWAIT: begin
            state_in = ST_EOUT;
         end
         ST_EOUT: begin
            if (can_emit) begin
               out_valid_in        = 1'b1;
               out_in.kind         = gpq_pkg::KIND_PALETTE;
               out_in.palette_argb = (32'(ei_ff) < 32'(live_ff)) ? pal_q : 32'd0;
               out_in.color_index  = ei_ff;
               out_in.error        = ovf_ff ? gpq_pkg::ERR_OVERFLOW : gpq_pkg::ERR_OK;
               out_in.last         = (ei_ff == 4'(EMIT - 1));
               if (ei_ff == 4'(EMIT - 1)) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  ei_in    = ei_ff + 4'd1;
                  state_in = ST_EADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         loaded_ff    <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         live_ff      <= '0;
         iss_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         loaded_ff    <= loaded_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
         live_ff      <= live_in;
         iss_ff       <= iss_in;
         pv_ff        <= pv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      out_ff   <= out_in;
      gaddr_ff <= gaddr_in;
      pidx_ff  <= pidx_in;
      have_ff  <= have_in;
      v_ff     <= v_in;
      vcnt_ff  <= vcnt_in;
      vcol_ff  <= vcol_in;
      s_ff     <= s_in;
      scnt_ff  <= scnt_in;
      scol_ff  <= scol_in;
      bd_ff    <= bd_in;
      ch_ff    <= ch_in;
      res_ff   <= res_in;
      p1_ff    <= p1_in;
      g_ff     <= g_in;
      gcnt_ff  <= gcnt_in;
      gcol_ff  <= gcol_in;
      rank_ff  <= rank_in;
      paddr_ff <= paddr_in;
      qslot_ff <= qslot_in;
      qerr_ff  <= qerr_in;
      ei_ff    <= ei_in;
   end

   // Result port.
   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_ff.kind;
   assign rsp.palette_argb = out_ff.palette_argb;
   assign rsp.color_index  = out_ff.color_index;
   assign rsp.error        = out_ff.error;
   assign rsp.last         = out_ff.last;

endmodule

### hw/rtl/greedy_palette_quantizer_unit.sv
// ----------------------------------------------------------------------------
// greedy_palette_quantizer_unit
// A pixel load steps through a key map read, a group table read and an update.
// A query does the same two reads, then follows the merge links to the surviving
// group and reads its palette color; an unknown color skips the link walk.
// The final load runs the merge loop: per merge two walks of the G groups plus
// four divisions, one per channel; ranking walks the G groups once per survivor.
// Reset clears all control state; the key map and group tables need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_palette_quantizer_unit #(
   parameter int MAX_PIXELS   = 4096,
   parameter int PALETTE_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   gpq_req_if.sink    req,
   gpq_rsp_if.source  rsp
);

   logic              q_valid;
   logic              q_pop;
   gpq_pkg::item_type q_item;

   // Front end: accept and classify request words.
   gpq_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   // Back end: tables, merging, ranking and results.
   gpq_back #(
      .MAX_PIXELS   (MAX_PIXELS),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

### tb/tb_greedy_palette_quantizer_unit.sv
// ----------------------------------------------------------------------------
// tb_greedy_palette_quantizer_unit
// Self-checking bench for the greedy palette quantizer. Pixel images are
// streamed in, and the palettes and index answers that come back are checked
// against a behavioral palette builder kept in the bench. A directed table
// comes first, followed by random images.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_palette_quantizer_unit;

   localparam int PIXEL_CAP = 4096;
   localparam int PAL_SLOTS = 16;

   logic clock;
   logic reset;

   gpq_req_if req ();
   gpq_rsp_if rsp ();

   greedy_palette_quantizer_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // One row of the directed table.
   typedef struct {
      logic             cmd;
      logic [31:0]      argb;
      logic             lastp;
      bit               typed;
      gpq_pkg::rsp_type want;
   } stim_row_type;

   // Palette builder state.
   int unsigned  key_map[int];
   logic [31:0]  grp_color[PIXEL_CAP];
   longint       grp_count[PIXEL_CAP];
   int           grp_merged[PIXEL_CAP];
   int           grp_slot[PIXEL_CAP];
   bit           grp_alive[PIXEL_CAP];
   int           grp_total;
   int           pix_loaded;
   bit           pix_overflow;
   bit           pal_ready;
   logic [31:0]  pal_color[PAL_SLOTS];

   gpq_pkg::rsp_type pending_words[$];
   int           mismatches;
   int           words_sent;
   int           words_seen;

   // Clock and reset.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("greedy_palette_quantizer_unit verification failed");
      $finish;
   end

   function automatic logic [15:0] group_key(logic [31:0] c);
      return {c[31:28], c[23:20], c[15:12], c[7:4]};
   endfunction

   function automatic int sq_distance(logic [31:0] x, logic [31:0] y);
      int acc;
      int d;
      acc = 0;
      for (int sh = 0; sh < 24; sh += 8) begin
         d = int'(x[sh +: 8]) - int'(y[sh +: 8]);
         acc += d * d;
      end
      return acc;
   endfunction

   // Merge groups until the palette fits, then rank survivors by count.
   task automatic build_palette();
      int live;
      int victim;
      int keep;
      int best;
      int d;
      int rank;
      int r;
      int steps;
      longint total;
      longint num;
      logic [31:0] mixed;
      bit have;
      live = grp_total;
      for (int g = 0; g < grp_total; g++) grp_alive[g] = 1'b1;
      while (live > PAL_SLOTS) begin
         victim = 0;
         have = 1'b0;
         for (int g = 0; g < grp_total; g++)
            if (grp_alive[g] && (!have || grp_count[g] <= grp_count[victim])) begin
               victim = g;
               have = 1'b1;
            end
         have = 1'b0;
         keep = 0;
         best = 0;
         for (int g = 0; g < grp_total; g++) begin
            if (!grp_alive[g] || g == victim) continue;
            d = sq_distance(grp_color[g], grp_color[victim]);
            if (!have || d < best || (d == best && grp_count[g] > grp_count[keep])) begin
               keep = g;
               best = d;
               have = 1'b1;
            end
         end
         total = grp_count[keep] + grp_count[victim];
         mixed = '0;
         for (int sh = 0; sh < 32; sh += 8) begin
            num = longint'(grp_color[keep][sh +: 8]) * grp_count[keep]
                + longint'(grp_color[victim][sh +: 8]) * grp_count[victim];
            mixed[sh +: 8] = 8'(num / total);
         end
         grp_color[keep] = mixed;
         grp_count[keep] = total;
         grp_merged[victim] = keep;
         grp_alive[victim] = 1'b0;
         live--;
      end
      for (int i = 0; i < PAL_SLOTS; i++) pal_color[i] = '0;
      for (int g = 0; g < grp_total; g++) begin
         if (!grp_alive[g]) continue;
         rank = 0;
         for (int h = 0; h < grp_total; h++)
            if (grp_alive[h] && (grp_count[h] > grp_count[g] ||
                                 (grp_count[h] == grp_count[g] && h < g)))
               rank++;
         grp_slot[g] = rank;
         if (rank < PAL_SLOTS) pal_color[rank] = grp_color[g];
      end
      // Follow merge links to the surviving group.
      for (int g = 0; g < grp_total; g++) begin
         r = g;
         steps = 0;
         while (!grp_alive[r] && steps < grp_total) begin
            r = grp_merged[r];
            steps++;
         end
         grp_slot[g] = grp_slot[r];
      end
   endtask

   // Work out the result words that one accepted input word causes.
   task automatic predict_word(logic cmd, logic [31:0] argb, logic lastp,
                               ref gpq_pkg::rsp_type words[$]);
      int key;
      int g;
      gpq_pkg::rsp_type w;
      key = int'(group_key(argb));
      if (cmd == gpq_pkg::CMD_QUERY) begin
         w = '{gpq_pkg::KIND_INDEX, 32'h0, 4'h0, gpq_pkg::ERR_UNKNOWN, 1'b0};
         if (pal_ready && key_map.exists(key)) begin
            g = key_map[key];
            w.color_index = 4'(grp_slot[g]);
            w.palette_argb = (grp_slot[g] < PAL_SLOTS) ? pal_color[grp_slot[g]] : '0;
            w.error = gpq_pkg::ERR_OK;
         end
         words.push_back(w);
         return;
      end
      if (pal_ready) begin
         key_map.delete();
         grp_total = 0;
         pix_loaded = 0;
         pix_overflow = 1'b0;
         pal_ready = 1'b0;
      end
      if (pix_loaded >= PIXEL_CAP) begin
         pix_overflow = 1'b1;
      end else begin
         if (key_map.exists(key)) begin
            grp_count[key_map[key]]++;
         end else begin
            key_map[key] = grp_total;
            grp_color[grp_total] = argb;
            grp_count[grp_total] = 1;
            grp_merged[grp_total] = grp_total;
            grp_total++;
         end
         pix_loaded++;
      end
      if (!lastp) return;
      build_palette();
      pal_ready = 1'b1;
      for (int i = 0; i < PAL_SLOTS; i++) begin
         w.kind = gpq_pkg::KIND_PALETTE;
         w.palette_argb = pal_color[i];
         w.color_index = 4'(i);
         w.error = pix_overflow ? gpq_pkg::ERR_OVERFLOW : gpq_pkg::ERR_OK;
         w.last = (i == PAL_SLOTS - 1);
         words.push_back(w);
      end
   endtask

   // Offer one word, with random idle cycles first, until it is accepted.
   task automatic send_word(logic cmd, logic [31:0] argb, logic lastp, bit typed,
                            gpq_pkg::rsp_type want);
      gpq_pkg::rsp_type words[$];
      bit calm;
      calm = (words_sent >= 60 && words_sent < 100);
      while (!calm && $urandom_range(99) < 32) begin
         req.valid <= 1'b0;
         req.cmd <= 1'($urandom);
         req.pixel_argb <= $urandom;
         req.last_pixel <= 1'($urandom);
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.pixel_argb <= argb;
      req.last_pixel <= lastp;
      do @(posedge clock); while (!req.ready);
      predict_word(cmd, argb, lastp, words);
      if (typed) pending_words.push_back(want);
      else foreach (words[i]) pending_words.push_back(words[i]);
      words_sent++;
      @(negedge clock);
   endtask

   // Result side: random stalls, one long hold-off, and a calm stretch.
   initial begin
      bit held;
      held = 1'b0;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!held && words_seen >= 20) begin
            held = 1'b1;
            rsp.ready <= 1'b0;
            repeat (500) @(negedge clock);
         end
         if (words_seen >= 40 && words_seen < 90) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(99) >= 32);
         @(negedge clock);
      end
   end

   // Compare every accepted result word with the oldest expected one.
   always @(posedge clock) begin
      gpq_pkg::rsp_type got;
      gpq_pkg::rsp_type exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.kind, rsp.palette_argb, rsp.color_index, rsp.error, rsp.last};
         words_seen <= words_seen + 1;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
         end else begin
            exp_w = pending_words.pop_front();
            if (got.kind !== exp_w.kind || got.palette_argb !== exp_w.palette_argb ||
                got.color_index !== exp_w.color_index || got.error !== exp_w.error ||
                got.last !== exp_w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", exp_w, got);
            end
         end
      end
   end

   // Stimulus.
   initial begin
      stim_row_type dir_rows[$];
      gpq_pkg::rsp_type none;
      gpq_pkg::rsp_type unknown_w;
      logic [31:0] pool[12];
      logic [31:0] used[$];
      logic [31:0] c;
      int n_pix;
      int n_q;
      none = '{gpq_pkg::KIND_PALETTE, 32'h0, 4'h0, gpq_pkg::ERR_OK, 1'b0};
      unknown_w = '{gpq_pkg::KIND_INDEX, 32'h0, 4'h0, gpq_pkg::ERR_UNKNOWN, 1'b0};
      mismatches = 0;
      words_sent = 0;
      words_seen = 0;
      grp_total = 0;
      pix_loaded = 0;
      pix_overflow = 1'b0;
      pal_ready = 1'b0;
      req.valid = 1'b0;
      req.cmd = gpq_pkg::CMD_LOAD;
      req.pixel_argb = '0;
      req.last_pixel = 1'b0;

      // Directed rows: query before any image, extremes, a shared key, ignored last flag.
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'h12345678, 1'b0, 1'b1, unknown_w});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'h00000000, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'hffffffff, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'hf0f0f0f0, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'h80808080, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'h7f7f7f7f, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'h0f0f0f0f, 1'b1, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'hfefdfcfb, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'h00000000, 1'b1, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'h7a7b7c7d, 1'b0, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'h12345678, 1'b0, 1'b1, unknown_w});
      dir_rows.push_back('{gpq_pkg::CMD_LOAD,  32'haa55aa55, 1'b1, 1'b0, none});
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'hffffffff, 1'b0, 1'b1, unknown_w});
      dir_rows.push_back('{gpq_pkg::CMD_QUERY, 32'haa55aa55, 1'b0, 1'b0, none});

      @(negedge clock);
      while (reset) @(negedge clock);
      foreach (dir_rows[i])
         send_word(dir_rows[i].cmd, dir_rows[i].argb, dir_rows[i].lastp,
                   dir_rows[i].typed, dir_rows[i].want);

      // Random images: a shared pool of colors gives repeated keys and count ties.
      while (words_sent < 130) begin
         foreach (pool[i]) pool[i] = $urandom;
         used.delete();
         n_pix = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 30);
         for (int p = 0; p < n_pix; p++) begin
            c = ($urandom_range(99) < 65) ? (pool[$urandom_range(11)] ^ ($urandom & 32'h0f0f0f0f))
                                           : $urandom;
            used.push_back(c);
            send_word(gpq_pkg::CMD_LOAD, c, p == n_pix - 1, 1'b0, none);
            if ($urandom_range(99) < 8)
               send_word(gpq_pkg::CMD_QUERY, $urandom, 1'($urandom), 1'b0, none);
         end
         n_q = $urandom_range(2, 6);
         for (int q = 0; q < n_q; q++) begin
            c = ($urandom_range(99) < 80) ? (used[$urandom_range(used.size() - 1)]
                                             ^ ($urandom & 32'h0f0f0f0f))
                                          : $urandom;
            send_word(gpq_pkg::CMD_QUERY, c, 1'($urandom), 1'b0, none);
         end
      end
      req.valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("greedy_palette_quantizer_unit verification clean");
      else
         $display("greedy_palette_quantizer_unit verification failed");
      $finish;
   end

endmodule
